>>> rtl/core/rau_pkg.sv
`default_nettype none
package rau_pkg;

  localparam int NUM_OUT_W = 33;
  localparam int DEN_OUT_W = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_ZERO_DEN = 2'd1,
    ERR_DIV_ZERO = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_GCD,
    ST_DIV,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic gcd_init;
    logic gcd_step;
    logic div_init;
    logic div_step;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic early;
    logic gcd_done;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/rau_ctrl.sv
`default_nettype none
module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output logic       busy,
  output logic       done,
  output ctrl_t      ctrl,
  input  wire stat_t stat
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = stat.early ? ST_DONE : ST_GCD;
      ST_GCD:  if (stat.gcd_done) state_next = ST_DIV;
      ST_DIV:  if (stat.div_done) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    busy = (state != ST_IDLE);
    done = 1'b0;
    unique case (state)
      ST_IDLE: ctrl.load = start;
      ST_MUL:  ctrl.mul = 1'b1;
      ST_SUM:  begin ctrl.sum = 1'b1; ctrl.gcd_init = 1'b1; end
      ST_GCD:  begin
        ctrl.gcd_step = ~stat.gcd_done;
        ctrl.div_init = stat.gcd_done;
      end
      ST_DIV:  ctrl.div_step = ~stat.div_done;
      ST_DONE: done = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/rau_dp.sv
`default_nettype none
module rau_dp
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire ctrl_t                           ctrl,
  output stat_t                                stat,
  input  wire logic [1:0]                      operation,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_denominator,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_denominator,
  output logic signed [NUM_OUT_W-1:0]          result_numerator,
  output logic [DEN_OUT_W-1:0]                 result_denominator,
  output logic [1:0]                           error_code
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int CW = $clog2(SW + 1);

  // operand magnitudes and signs
  logic [W-1:0] an_m, ad_m, bn_m, bd_m;
  logic         an_s, ad_s, bn_s, bd_s;
  op_t          op;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op   <= op_t'(operation);
      an_m <= mag(a_numerator);   an_s <= a_numerator[W-1];
      ad_m <= mag(a_denominator); ad_s <= a_denominator[W-1];
      bn_m <= mag(b_numerator);
      bn_s <= b_numerator[W-1] ^ (operation == OP_SUB);
      bd_m <= mag(b_denominator); bd_s <= b_denominator[W-1];
    end
  end

  // cross products (straight products for multiply), registered
  logic [PW-1:0] p1, p2, pd;
  logic          p1_s, p2_s, pd_s;
  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      unique case (op)
        OP_MUL: begin
          p1 <= an_m * bn_m; p1_s <= an_s ^ bn_s;
          p2 <= '0;          p2_s <= 1'b0;
          pd <= ad_m * bd_m; pd_s <= ad_s ^ bd_s;
        end
        OP_DIV: begin
          p1 <= an_m * bd_m; p1_s <= an_s ^ bd_s;
          p2 <= '0;          p2_s <= 1'b0;
          pd <= ad_m * bn_m; pd_s <= ad_s ^ bn_s;
        end
        default: begin
          p1 <= an_m * bd_m; p1_s <= an_s ^ bd_s;
          p2 <= ad_m * bn_m; p2_s <= ad_s ^ bn_s;
          pd <= ad_m * bd_m; pd_s <= ad_s ^ bd_s;
        end
      endcase
    end
  end

  // signed-magnitude sum of the numerator terms
  logic [SW-1:0] sum_m;
  logic          sum_s;
  always_comb begin
    if (p1_s == p2_s) begin
      sum_m = {1'b0, p1} + {1'b0, p2}; sum_s = p1_s;
    end else if (p1 >= p2) begin
      sum_m = {1'b0, p1 - p2}; sum_s = p1_s;
    end else begin
      sum_m = {1'b0, p2 - p1}; sum_s = p2_s;
    end
  end

  logic zero_den, div_zero, early;
  assign zero_den = (ad_m == '0) || (bd_m == '0);
  assign div_zero = (op == OP_DIV) && (bn_m == '0);
  assign early    = zero_den || div_zero || (sum_m == '0);
  assign stat.early = early;

  // result sign: numerator sign flipped by denominator sign
  logic          r_s;
  logic [SW-1:0] num_m, den_m;
  logic [SW-1:0] gx, gy;
  logic [CW-1:0] gk;

  // binary gcd: strip common twos, then subtract-and-shift
  logic gx_even, gy_even;
  assign gx_even = ~gx[0];
  assign gy_even = ~gy[0];
  assign stat.gcd_done = (gy == '0);

  logic [SW-1:0] g;
  assign g = gx << gk;

  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      num_m <= sum_m;
      den_m <= {1'b0, pd};
      r_s   <= sum_s ^ pd_s;
    end
    if (ctrl.gcd_init) begin
      gx <= sum_m;
      gy <= {1'b0, pd};
      gk <= '0;
    end else if (ctrl.gcd_step) begin
      if (gx_even && gy_even) begin
        gx <= gx >> 1; gy <= gy >> 1; gk <= gk + 1'b1;
      end else if (gx_even) begin
        gx <= gx >> 1;
      end else if (gy_even) begin
        gy <= gy >> 1;
      end else if (gx >= gy) begin
        gx <= gy; gy <= (gx - gy) >> 1;
      end else begin
        gy <= (gy - gx) >> 1;
      end
    end
  end

  // two restoring dividers sharing one counter, one quotient bit a cycle
  logic [SW-1:0] dvs, qn, qd, rn, rd;
  logic [CW-1:0] dcnt;
  logic [SW:0]   rn_t, rd_t;
  assign rn_t = {rn, qn[SW-1]};
  assign rd_t = {rd, qd[SW-1]};
  assign stat.div_done = (dcnt == '0);

  always_ff @(posedge clk) begin
    if (ctrl.div_init) begin
      dvs  <= g;
      qn   <= num_m;
      qd   <= den_m;
      rn   <= '0;
      rd   <= '0;
      dcnt <= CW'(SW);
    end else if (ctrl.div_step) begin
      dcnt <= dcnt - 1'b1;
      if (rn_t >= {1'b0, dvs}) begin
        rn <= SW'(rn_t - {1'b0, dvs}); qn <= {qn[SW-2:0], 1'b1};
      end else begin
        rn <= rn_t[SW-1:0];            qn <= {qn[SW-2:0], 1'b0};
      end
      if (rd_t >= {1'b0, dvs}) begin
        rd <= SW'(rd_t - {1'b0, dvs}); qd <= {qd[SW-2:0], 1'b1};
      end else begin
        rd <= rd_t[SW-1:0];            qd <= {qd[SW-2:0], 1'b0};
      end
    end
  end

  // early result captured at the sum step
  logic          early_q;
  err_t          err_q;
  always_ff @(posedge clk) begin
    if (ctrl.sum) begin
      early_q <= early;
      err_q   <= zero_den ? ERR_ZERO_DEN : (div_zero ? ERR_DIV_ZERO : ERR_NONE);
    end
  end

  logic [SW:0] nsx;
  assign nsx = r_s ? (~{1'b0, qn} + 1'b1) : {1'b0, qn};

  always_comb begin
    error_code = err_q;
    if (early_q) begin
      result_numerator   = '0;
      result_denominator = (err_q == ERR_NONE) ? DEN_OUT_W'(1) : '0;
    end else begin
      result_numerator   = NUM_OUT_W'(nsx);
      result_denominator = DEN_OUT_W'(qd);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rational_arithmetic_unit_core.sv
`default_nettype none
// Channel  | Signals                                        | Handshake
// request  | operation, a_/b_numerator, a_/b_denominator    | start & !busy
// result   | result_numerator, result_denominator, error_code | done, one cycle
//
// Error or zero results skip the gcd and divide steps: multiply, sum, done.
// Otherwise: multiply, sum, binary gcd steps, then 2*OPERAND_WIDTH+1 divide
// steps, done.
// busy is high from acceptance until the done cycle ends.
// Synchronous reset returns the controller to idle. The receiver cannot stall.
module rational_arithmetic_unit_core
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  output logic                                 done,
  input  wire logic [1:0]                      operation,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0] a_denominator,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0] b_denominator,
  output logic signed [NUM_OUT_W-1:0]          result_numerator,
  output logic [DEN_OUT_W-1:0]                 result_denominator,
  output logic [1:0]                           error_code
);

  ctrl_t ctrl;
  stat_t stat;

  rau_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .ctrl (ctrl),
    .stat (stat)
  );

  rau_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk               (clk),
    .ctrl              (ctrl),
    .stat              (stat),
    .operation         (operation),
    .a_numerator       (a_numerator),
    .a_denominator     (a_denominator),
    .b_numerator       (b_numerator),
    .b_denominator     (b_denominator),
    .result_numerator  (result_numerator),
    .result_denominator(result_denominator),
    .error_code        (error_code)
  );

endmodule
`default_nettype wire

>>> verif/rational_arithmetic_unit_core_tb.sv
`default_nettype none
module rational_arithmetic_unit_core_tb
  import rau_pkg::*;
;

  localparam int W = 16;

  typedef struct {
    logic [1:0] op;
    logic signed [W-1:0] an;
    logic signed [W-1:0] ad;
    logic signed [W-1:0] bn;
    logic signed [W-1:0] bd;
  } req_t;

  typedef struct {
    logic signed [NUM_OUT_W-1:0] num;
    logic [DEN_OUT_W-1:0] den;
    logic [1:0] err;
  } frac_t;

  // directed row: request plus optional typed-in answer
  typedef struct {
    req_t rq;
    bit known;
    frac_t ans;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [1:0] operation = '0;
  logic signed [W-1:0] a_numerator = '0, a_denominator = '0;
  logic signed [W-1:0] b_numerator = '0, b_denominator = '0;
  logic signed [NUM_OUT_W-1:0] result_numerator;
  logic [DEN_OUT_W-1:0] result_denominator;
  logic [1:0] error_code;

  frac_t pending_q[$];
  int fail_count = 0;
  int sender_idle_pct = 0;

  rational_arithmetic_unit_core #(.OPERAND_WIDTH(W)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .operation(operation), .a_numerator(a_numerator), .a_denominator(a_denominator),
    .b_numerator(b_numerator), .b_denominator(b_denominator),
    .result_numerator(result_numerator), .result_denominator(result_denominator),
    .error_code(error_code)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("status: fail");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  // exact reduced fraction of a request
  function automatic frac_t reduce_fraction(req_t r);
    frac_t f;
    longint n, d, x, y, t;
    longint an, ad, bn, bd;
    an = r.an; ad = r.ad; bn = r.bn; bd = r.bd;
    if (ad == 0 || bd == 0) begin
      f.num = '0; f.den = '0; f.err = ERR_ZERO_DEN;
      return f;
    end
    if (r.op == OP_DIV && bn == 0) begin
      f.num = '0; f.den = '0; f.err = ERR_DIV_ZERO;
      return f;
    end
    case (r.op)
      OP_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
      OP_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
      OP_MUL: begin n = an * bn; d = ad * bd; end
      default: begin n = an * bd; d = ad * bn; end
    endcase
    f.err = ERR_NONE;
    if (n == 0) begin
      f.num = '0; f.den = DEN_OUT_W'(1);
      return f;
    end
    if (d < 0) begin n = -n; d = -d; end
    x = (n < 0) ? -n : n;
    y = d;
    while (y != 0) begin
      t = x % y; x = y; y = t;
    end
    n = n / x; d = d / x;
    f.num = n[NUM_OUT_W-1:0];
    f.den = d[DEN_OUT_W-1:0];
    return f;
  endfunction

  // result checker
  always @(posedge clk) begin
    frac_t want;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $display("unexpected result");
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (result_numerator !== want.num)
          report("numerator", result_numerator, want.num);
        if (result_denominator !== want.den)
          report("denominator", result_denominator, want.den);
        if (error_code !== want.err) report("error_code", error_code, want.err);
      end
    end
  end

  function automatic logic signed [W-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3, 4: return $signed(16'($urandom_range(0, 12))) - 16'sd6;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [W-1:0] rand_denominator();
    if ($urandom_range(0, 49) == 0) return '0;
    return ($urandom_range(0, 3) == 0) ? rand_operand() | 16'sd1 : 16'($urandom) | 16'sd1;
  endfunction

  // issue one request and record its expected result
  task automatic send_request(req_t r, bit known, frac_t ans);
    frac_t want;
    want = reduce_fraction(r);
    if (known && (want.num !== ans.num || want.den !== ans.den ||
                  want.err !== ans.err)) begin
      $display("table entry disagrees with predictor");
      fail_count++;
    end
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    operation <= r.op;
    a_numerator <= r.an;
    a_denominator <= r.ad;
    b_numerator <= r.bn;
    b_denominator <= r.bd;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(known ? ans : want);
    @(negedge clk);
  endtask

  function automatic row_t mk(logic [1:0] op, int an, int ad, int bn, int bd,
                              bit known = 0, longint n = 0, longint d = 0,
                              logic [1:0] e = ERR_NONE);
    row_t r;
    r.rq.op = op; r.rq.an = W'(an); r.rq.ad = W'(ad); r.rq.bn = W'(bn); r.rq.bd = W'(bd);
    r.known = known;
    r.ans.num = NUM_OUT_W'(n); r.ans.den = DEN_OUT_W'(d); r.ans.err = e;
    return r;
  endfunction

  initial begin
    row_t dir_tbl[$];
    req_t r;
    frac_t none;
    int guard;
    none = '{default: '0};
    dir_tbl = '{
      mk(OP_ADD, 1, 2, 1, 3, 1, 5, 6),
      mk(OP_SUB, 1, 2, 1, 2, 1, 0, 1),
      mk(OP_MUL, 2, 3, 3, 4, 1, 1, 2),
      mk(OP_DIV, 1, 2, 1, 4, 1, 2, 1),
      mk(OP_ADD, 1, 0, 1, 1, 1, 0, 0, ERR_ZERO_DEN),
      mk(OP_DIV, 1, 1, 1, 0, 1, 0, 0, ERR_ZERO_DEN),
      mk(OP_DIV, 0, 0, 0, 1, 1, 0, 0, ERR_ZERO_DEN),
      mk(OP_DIV, 5, 7, 0, 3, 1, 0, 0, ERR_DIV_ZERO),
      mk(OP_MUL, 0, -5, 7, 9, 1, 0, 1),
      mk(OP_ADD, 1, -2, 0, 1, 1, -1, 2),
      mk(OP_MUL, -32768, 1, -32768, 1, 1, 64'sd1073741824, 1),
      mk(OP_MUL, 1, -32768, 1, -32768, 1, 1, 64'd1073741824),
      mk(OP_ADD, -32768, 1, -32768, 1, 1, -65536, 1),
      mk(OP_SUB, 32767, 1, -32768, 1, 1, 65535, 1),
      mk(OP_ADD, 32767, 32766, 32767, 32765),
      mk(OP_SUB, -32768, 32767, 32767, -32768),
      mk(OP_DIV, -32768, 32767, 32767, -32768),
      mk(OP_DIV, 32767, -32768, -32768, 32767),
      mk(OP_MUL, 32767, -1, -32768, -1),
      mk(OP_ADD, -1, -1, -1, -1, 1, 2, 1),
      mk(OP_DIV, -3, 4, 3, -4, 1, 1, 1)
    };
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) send_request(dir_tbl[i].rq, dir_tbl[i].known, dir_tbl[i].ans);

    // random phases: none, sender idle 74%, quiet drain, idle 8%
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1) ? 74 : (ph == 3) ? 8 : 0;
      if (ph == 2) begin
        start <= 1'b0;
        @(negedge clk);
        guard = 0;
        while (pending_q.size() != 0 && guard < 2000) begin
          @(negedge clk); guard++;
        end
      end
      repeat (350) begin
        r.op = 2'($urandom);
        r.an = rand_operand();
        r.bn = rand_operand();
        r.ad = rand_denominator();
        r.bd = rand_denominator();
        send_request(r, 0, none);
      end
    end

    start <= 1'b0;
    @(negedge clk);
    guard = 0;
    while (pending_q.size() != 0 && guard < 2000) begin
      @(negedge clk); guard++;
    end
    repeat (200) @(negedge clk);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
rtl/core/rau_pkg.sv
rtl/core/rau_ctrl.sv
rtl/core/rau_dp.sv
rtl/core/rational_arithmetic_unit_core.sv
verif/rational_arithmetic_unit_core_tb.sv
